/* hw/rtl/itp_pkg.sv */
// Shared constants and operator ranking for the infix to postfix converter.
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

   typedef logic [1:0] rank_type;
   typedef logic [7:0] symbol_type;

   localparam logic KIND_EXPR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam symbol_type OP_MUL = 8'h2A;
   localparam symbol_type OP_DIV = 8'h2F;
   localparam symbol_type OP_ADD = 8'h2B;
   localparam symbol_type OP_SUB = 8'h2D;

   localparam rank_type RANK_NONE = 2'd0;
   localparam rank_type RANK_LOW  = 2'd2;
   localparam rank_type RANK_HIGH = 2'd3;

   function automatic rank_type rank_of(input symbol_type c);
      rank_type r;
      r = RANK_NONE;
      if (c == OP_MUL || c == OP_DIV) begin
         r = RANK_HIGH;
      end else if (c == OP_ADD || c == OP_SUB) begin
         r = RANK_LOW;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/itp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module itp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/infix_to_postfix_converter_core.sv */
// Infix to postfix converter: operator stack in RAM driven by a small sequencer.
// Usage:
//   req_ channel: one infix character per transaction (req_kind = 0) or an end
//   mark (req_kind = 1) that flushes the operator stack.
//   rsp_ channel: postfix characters; an end mark closes with a terminator
//   (rsp_end_marker = 1, rsp_out_symbol = 0, rsp_overflow_seen = sticky drop
//   flag for the expression). rsp_last flags the final result of each request.
// Timing and throughput:
//   An operand is registered into the output when taken and shows on rsp_ the
//   next cycle; a new request can be taken every cycle while the output
//   register drains. An operator or end mark pops stacked entries in S_CHECK:
//   each pop is one read of the single stack RAM port, whose registered read
//   data sets the pace of the pops. An end mark then emits its terminator
//   from S_FIN.
//   req_ready is low while a request is in progress.
// Reset (synchronous, active high) empties the stack and clears the overflow
// flag; stack RAM contents are not cleared and need no clearing pass.
// A stall on rsp_ready holds the output register; the sequencer waits on it
// and no result is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter_core #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_kind,
   input  wire logic [7:0] req_symbol,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_symbol,
   output logic            rsp_end_marker,
   output logic            rsp_overflow_seen,
   output logic            rsp_last
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_FIN   = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic                  kind_ff, kind_in;
   itp_pkg::symbol_type   sym_ff, sym_in;
   itp_pkg::rank_type     rank_ff, rank_in;
   itp_pkg::symbol_type   pend_ff, pend_in;
   logic                  pend_valid_ff, pend_valid_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   itp_pkg::symbol_type   rsp_sym_ff;
   logic                  rsp_end_ff, rsp_ovf_ff, rsp_last_ff;

   logic                  emit, emit_end, emit_ovf, emit_last;
   itp_pkg::symbol_type   emit_sym;
   logic                  push_req, pop;
   logic                  rd_en, wr_en;
   logic [AW-1:0]         rd_addr;
   itp_pkg::symbol_type   rd_data;
   logic [CW-1:0]         cnt_m1, cnt_m2;
   logic                  out_free, req_fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign cnt_m1    = count_ff - CW'(1);
   assign cnt_m2    = count_ff - CW'(2);
   assign wr_en     = push_req && (count_ff != CW'(STACK_DEPTH));

   itp_ram #(
      .WIDTH (8),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (sym_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      kind_in       = kind_ff;
      sym_in        = sym_ff;
      rank_in       = rank_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      emit          = 1'b0;
      emit_sym      = '0;
      emit_end      = 1'b0;
      emit_ovf      = 1'b0;
      emit_last     = 1'b0;
      push_req      = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = cnt_m1[AW-1:0];
      pop           = (kind_ff == itp_pkg::KIND_END) ||
                      (itp_pkg::rank_of(rd_data) >= rank_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in       = req_kind;
               sym_in        = req_symbol;
               rank_in       = itp_pkg::rank_of(req_symbol);
               pend_valid_in = 1'b0;
               if (req_kind == itp_pkg::KIND_EXPR &&
                   itp_pkg::rank_of(req_symbol) == itp_pkg::RANK_NONE) begin
                  emit      = 1'b1;
                  emit_sym  = req_symbol;
                  emit_last = 1'b1;
               end else if (count_ff != '0) begin
                  rd_en    = 1'b1;
                  rd_addr  = cnt_m1[AW-1:0];
                  state_in = S_CHECK;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_CHECK: begin
            // a popped entry is held back in pend_ff until we know if it is the last
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  emit      = 1'b1;
                  emit_sym  = pend_ff;
                  emit_last = !pop;
               end
               if (pop) begin
                  pend_in       = rd_data;
                  pend_valid_in = 1'b1;
                  count_in      = cnt_m1;
                  if (cnt_m1 != '0) begin
                     rd_en   = 1'b1;
                     rd_addr = cnt_m2[AW-1:0];
                  end else begin
                     state_in = S_FIN;
                  end
               end else begin
                  pend_valid_in = 1'b0;
                  push_req      = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         S_FIN: begin
            if (pend_valid_ff) begin
               if (out_free) begin
                  emit          = 1'b1;
                  emit_sym      = pend_ff;
                  emit_last     = (kind_ff == itp_pkg::KIND_EXPR);
                  pend_valid_in = 1'b0;
                  if (kind_ff == itp_pkg::KIND_EXPR) begin
                     push_req = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            end else if (kind_ff == itp_pkg::KIND_END) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_end  = 1'b1;
                  emit_ovf  = ovf_ff;
                  emit_last = 1'b1;
                  ovf_in    = 1'b0;
                  state_in  = S_IDLE;
               end
            end else begin
               push_req = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (push_req) begin
         if (count_ff == CW'(STACK_DEPTH)) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      sym_ff  <= sym_in;
      rank_ff <= rank_in;
      pend_ff <= pend_in;
      if (emit) begin
         rsp_sym_ff  <= emit_sym;
         rsp_end_ff  <= emit_end;
         rsp_ovf_ff  <= emit_ovf;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_symbol    = rsp_sym_ff;
   assign rsp_end_marker    = rsp_end_ff;
   assign rsp_overflow_seen = rsp_ovf_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/itp_checker.sv */
// Port-level assertions for the infix to postfix converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module itp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_kind,
   input wire logic [7:0] req_symbol,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_symbol,
   input wire logic       rsp_end_marker,
   input wire logic       rsp_overflow_seen,
   input wire logic       rsp_last
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_symbol) &&
      $stable(rsp_end_marker) && $stable(rsp_overflow_seen) && $stable(rsp_last))
      else $error("rsp transaction changed while stalled");

   a_term_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_marker |-> rsp_out_symbol == 8'h00 && rsp_last)
      else $error("terminator not zero or not last");

   a_ovf_only_term: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_marker |-> !rsp_overflow_seen)
      else $error("overflow reported on a non-terminator");

   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_ready)
      else $error("request taken with output register full");

   a_operand_pass: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == itp_pkg::KIND_EXPR &&
      itp_pkg::rank_of(req_symbol) == itp_pkg::RANK_NONE
      |=> rsp_valid && rsp_last && !rsp_end_marker &&
          rsp_out_symbol == $past(req_symbol))
      else $error("operand not passed through next cycle");

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_kind          (req_kind),
   .req_symbol        (req_symbol),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_symbol    (rsp_out_symbol),
   .rsp_end_marker    (rsp_end_marker),
   .rsp_overflow_seen (rsp_overflow_seen),
   .rsp_last          (rsp_last)
);

`default_nettype wire

/* test/postfix_checker.sv */
// Checker for the infix to postfix converter: predicts the postfix stream and compares it.
`timescale 1ns / 1ps

module postfix_checker #(
   parameter int STACK_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_symbol,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_symbol,
   input  logic        rsp_end_marker,
   input  logic        rsp_overflow_seen,
   input  logic        rsp_last,
   output int unsigned error_count,
   output int unsigned pending,
   output int unsigned results_seen
);

   typedef struct packed {
      itp_pkg::symbol_type sym;
      logic                end_marker;
      logic                overflow;
      logic                last;
   } postfix_type;

   itp_pkg::symbol_type op_stack [STACK_DEPTH];
   int                  op_count  = 0;
   logic                drop_flag = 1'b0;
   postfix_type         postfix_q [$];
   int unsigned         errs = 0;
   int unsigned         seen = 0;

   function automatic itp_pkg::rank_type precedence(input itp_pkg::symbol_type c);
      itp_pkg::rank_type r;
      case (c)
         itp_pkg::OP_MUL, itp_pkg::OP_DIV: r = itp_pkg::RANK_HIGH;
         itp_pkg::OP_ADD, itp_pkg::OP_SUB: r = itp_pkg::RANK_LOW;
         default:                          r = itp_pkg::RANK_NONE;
      endcase
      return r;
   endfunction

   task automatic flag_mismatch(input string field, input logic [7:0] got,
                                input logic [7:0] want);
      $display("checker: result %0d %s mismatch: got %h, expected %h",
               seen, field, got, want);
      errs++;
   endtask

   // Shunting-yard step for one accepted request; queues the postfix it produces.
   task automatic shunt(input logic kind, input itp_pkg::symbol_type sym);
      postfix_type       batch [$];
      itp_pkg::rank_type r;
      if (kind == itp_pkg::KIND_END) begin
         while (op_count > 0) begin
            op_count--;
            batch.push_back('{op_stack[op_count], 1'b0, 1'b0, 1'b0});
         end
         batch.push_back('{8'h00, 1'b1, drop_flag, 1'b0});
         drop_flag = 1'b0;
      end else begin
         r = precedence(sym);
         if (r == itp_pkg::RANK_NONE) begin
            batch.push_back('{sym, 1'b0, 1'b0, 1'b0});
         end else begin
            while (op_count > 0 && precedence(op_stack[op_count - 1]) >= r) begin
               op_count--;
               batch.push_back('{op_stack[op_count], 1'b0, 1'b0, 1'b0});
            end
            if (op_count >= STACK_DEPTH) begin
               drop_flag = 1'b1;
            end else begin
               op_stack[op_count] = sym;
               op_count++;
            end
         end
      end
      if (batch.size() > 0) begin
         batch[batch.size() - 1].last = 1'b1;
      end
      foreach (batch[i]) begin
         postfix_q.push_back(batch[i]);
      end
   endtask

   always @(posedge clock) begin
      postfix_type want;
      if (reset) begin
         op_count = 0;
         drop_flag = 1'b0;
         postfix_q.delete();
      end else begin
         // a response at this edge always belongs to an earlier request
         if (req_valid && req_ready) begin
            shunt(req_kind, req_symbol);
         end
         if (rsp_valid && rsp_ready) begin
            if (postfix_q.size() == 0) begin
               flag_mismatch("unexpected transaction", rsp_out_symbol, 8'h00);
            end else begin
               want = postfix_q.pop_front();
               if (rsp_out_symbol !== want.sym) begin
                  flag_mismatch("out_symbol", rsp_out_symbol, want.sym);
               end
               if (rsp_end_marker !== want.end_marker) begin
                  flag_mismatch("end_marker", {7'd0, rsp_end_marker}, {7'd0, want.end_marker});
               end
               if (rsp_overflow_seen !== want.overflow) begin
                  flag_mismatch("overflow_seen", {7'd0, rsp_overflow_seen},
                                {7'd0, want.overflow});
               end
               if (rsp_last !== want.last) begin
                  flag_mismatch("last", {7'd0, rsp_last}, {7'd0, want.last});
               end
            end
            seen++;
         end
      end
      error_count  <= errs;
      pending      <= postfix_q.size();
      results_seen <= seen;
   end

endmodule

/* test/tb.sv */
// Testbench top for the infix to postfix converter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;

   localparam int STACK_DEPTH  = 32;
   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 200;
   localparam int RANDOM_ITEMS = 100;
   localparam int SETTLE       = 50;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_valid  = 1'b0;
   logic       req_kind   = itp_pkg::KIND_EXPR;
   logic [7:0] req_symbol = 8'h00;
   logic       rsp_ready  = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_out_symbol;
   logic       rsp_end_marker;
   logic       rsp_overflow_seen;
   logic       rsp_last;

   int unsigned error_count;
   int unsigned pending;
   int unsigned results_seen;

   int hold_req   = 0;
   int items_sent = 0;
   int end_marks  = 0;
   int burst_left = 0;
   bit gaps_on    = 1'b1;

   infix_to_postfix_converter_core #(
      .STACK_DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_kind, .req_symbol,
      .rsp_valid, .rsp_ready, .rsp_out_symbol, .rsp_end_marker,
      .rsp_overflow_seen, .rsp_last
   );

   postfix_checker #(
      .STACK_DEPTH(STACK_DEPTH)
   ) i_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_kind, .req_symbol,
      .rsp_valid, .rsp_ready, .rsp_out_symbol, .rsp_end_marker,
      .rsp_overflow_seen, .rsp_last,
      .error_count, .pending, .results_seen
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Offer one transaction and wait for it to be taken; bursts with random gaps.
   task automatic send(input logic kind, input itp_pkg::symbol_type sym);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 10) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_symbol <= sym;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (kind == itp_pkg::KIND_END) begin
         end_marks++;
      end
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      burst_left = 0;
      // pending is registered and lags the edge
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic itp_pkg::symbol_type pick_operand();
      itp_pkg::symbol_type s;
      do begin
         if ($urandom_range(0, 3) == 0) begin
            s = 8'($urandom_range(0, 255));
         end else begin
            s = 8'(8'h61 + $urandom_range(0, 25));
         end
      end while (s == itp_pkg::OP_MUL || s == itp_pkg::OP_DIV ||
                 s == itp_pkg::OP_ADD || s == itp_pkg::OP_SUB);
      return s;
   endfunction

   function automatic itp_pkg::symbol_type pick_operator();
      itp_pkg::symbol_type s;
      case ($urandom_range(0, 3))
         0:       s = itp_pkg::OP_MUL;
         1:       s = itp_pkg::OP_DIV;
         2:       s = itp_pkg::OP_ADD;
         default: s = itp_pkg::OP_SUB;
      endcase
      return s;
   endfunction

   task automatic send_expression(input int operands);
      send(itp_pkg::KIND_EXPR, pick_operand());
      repeat (operands - 1) begin
         send(itp_pkg::KIND_EXPR, pick_operator());
         send(itp_pkg::KIND_EXPR, pick_operand());
      end
      send(itp_pkg::KIND_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_noise();
      if ($urandom_range(0, 7) == 0) begin
         send(itp_pkg::KIND_END, 8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 1) == 0) begin
         send(itp_pkg::KIND_EXPR, pick_operator());
      end else begin
         send(itp_pkg::KIND_EXPR, 8'($urandom_range(0, 255)));
      end
   endtask

   // Receiver: ready runs of its own, plus a long hold-off on request.
   initial begin : receiver
      int   holds_done;
      int   run;
      logic level;
      holds_done = 0;
      forever begin
         if (hold_req != holds_done) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               level = 1'b1;
               run = $urandom_range(10, 40);
            end else begin
               level = 1'($urandom_range(0, 1));
               run = $urandom_range(1, 6);
            end
            rsp_ready <= level;
            repeat (run) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      int  start;
      int  done_items;
      bit  held;
      bit  drained;
      held = 1'b0;
      drained = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // precedence, all four operators, first operator with nothing to pop
      send(itp_pkg::KIND_EXPR, "a");
      send(itp_pkg::KIND_EXPR, itp_pkg::OP_ADD);
      send(itp_pkg::KIND_EXPR, "b");
      send(itp_pkg::KIND_EXPR, itp_pkg::OP_MUL);
      send(itp_pkg::KIND_EXPR, "c");
      send(itp_pkg::KIND_EXPR, itp_pkg::OP_SUB);
      send(itp_pkg::KIND_EXPR, "d");
      send(itp_pkg::KIND_EXPR, itp_pkg::OP_DIV);
      send(itp_pkg::KIND_EXPR, "e");
      send(itp_pkg::KIND_END, 8'h00);
      // byte extremes and parentheses as operands, equal-rank pops
      send(itp_pkg::KIND_EXPR, 8'h00);
      send(itp_pkg::KIND_EXPR, itp_pkg::OP_MUL);
      send(itp_pkg::KIND_EXPR, 8'hFF);
      send(itp_pkg::KIND_EXPR, itp_pkg::OP_DIV);
      send(itp_pkg::KIND_EXPR, 8'h28);
      send(itp_pkg::KIND_EXPR, itp_pkg::OP_ADD);
      send(itp_pkg::KIND_EXPR, 8'h29);
      send(itp_pkg::KIND_END, 8'hFF);
      // end mark on an empty stack, then back-to-back operators
      send(itp_pkg::KIND_END, 8'h5A);
      send(itp_pkg::KIND_EXPR, itp_pkg::OP_SUB);
      send(itp_pkg::KIND_EXPR, itp_pkg::OP_SUB);
      send(itp_pkg::KIND_END, 8'hA5);

      start = items_sent;
      done_items = 0;
      while (done_items < RANDOM_ITEMS) begin
         if (!held && done_items > 30) begin
            // stall the output while requests keep coming
            hold_req <= hold_req + 1;
            held = 1'b1;
         end
         if (!drained && done_items > 80) begin
            drain_all();
            drained = 1'b1;
         end
         gaps_on = !(done_items > 50 && done_items < 70);
         if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 9) == 0) begin
               send_expression($urandom_range(7, 20));
            end else begin
               send_expression($urandom_range(1, 6));
            end
         end else begin
            send_noise();
         end
         done_items = items_sent - start;
      end

      drain_all();
      repeat (SETTLE) @(posedge clock);

      $display("tb: %0d transactions sent (%0d end marks), %0d results checked",
               items_sent, end_marks, results_seen);
      $display("tb: covered a %0d-cycle output hold-off and a full drain pause",
               HOLD_CYCLES);
      if (error_count == 0 && pending == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

/* infix_to_postfix_converter_core.f */
hw/rtl/itp_pkg.sv
hw/rtl/itp_ram.sv
hw/rtl/infix_to_postfix_converter_core.sv
hw/rtl/itp_checker.sv
test/postfix_checker.sv
test/tb.sv
